### src/hsv_to_rgb_converter_defines.svh
// Assertion macros shared by the HSV to RGB converter RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define HSV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define HSV_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HSV_ASSERT(label, clk, rst, prop, msg)
`define HSV_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### src/hsv2rgb_pkg.sv
// Widths, arithmetic constants and sector codes for the HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

   localparam int HUE_W  = 16;
   localparam int PCT_W  = 7;
   localparam int CHAN_W = 8;

   // Pipeline depth: one multiplier per stage.
   localparam int NUM_STAGES = 6;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   localparam int HUE_MOD    = 360;
   localparam int SECTOR_DEG = 60;

   // Reciprocals, rounded up, with the shift that goes with each.
   // ceil(2^24 / 360): exact quotient for every 16-bit hue.
   localparam logic [15:0] HUE_RECIP    = 16'd46604;
   localparam int          HUE_SHIFT    = 24;
   // ceil(2^19 / 100): exact quotient up to 25500.
   localparam logic [12:0] DIV100_RECIP = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // ceil(2^20 / 60): exact quotient up to 255 * 59.
   localparam logic [14:0] DIV60_RECIP  = 15'd17477;
   localparam int          DIV60_SHIFT  = 20;

   // Which channel holds the peak and which one ramps in each 60-degree sector.
   typedef enum logic [2:0] {
      SEC_R_PEAK_G_UP   = 3'd0,
      SEC_G_PEAK_R_DOWN = 3'd1,
      SEC_G_PEAK_B_UP   = 3'd2,
      SEC_B_PEAK_G_DOWN = 3'd3,
      SEC_B_PEAK_R_UP   = 3'd4,
      SEC_R_PEAK_B_DOWN = 3'd5
   } sector_type;

endpackage

### src/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: a six-stage pipeline with valid bits per stage.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_defines.svh.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   hue[15:0] saturation[6:0] brightness[6:0]
//   rsp_      out        rsp_valid/rsp_stall   red[7:0] green[7:0] blue[7:0] range_error
//
// One beat is accepted per clock while req_stall is low, and each request beat gives
// exactly one response beat, passing through six register stages, each built round
// one multiplier.
// Reset clears only the stage valid bits; the data registers are left as they are.
// A response stall holds the output stage and backs up only as far as there are
// full stages, so empty stages are filled while the output waits. req_stall rises
// only when all six stages hold beats and the output is stalled.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]      req_hue,
   input  logic [hsv2rgb_pkg::PCT_W-1:0]      req_saturation,
   input  logic [hsv2rgb_pkg::PCT_W-1:0]      req_brightness,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hsv2rgb_pkg::CHAN_W-1:0]     rsp_red,
   output logic [hsv2rgb_pkg::CHAN_W-1:0]     rsp_green,
   output logic [hsv2rgb_pkg::CHAN_W-1:0]     rsp_blue,
   output logic                               rsp_range_error
);
   import hsv2rgb_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   // ------------------------------------------------------------------
   // Stage handshake. A stage loads whenever it is empty or the stage
   // after it is loading, so a bubble anywhere is squeezed out.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] ready;

   always_comb begin
      ready[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[LAST];

   // ------------------------------------------------------------------
   // Stage 0: range check, clamping, hue quotient by reciprocal, and
   // brightness times 255 as a shift and subtract.
   // ------------------------------------------------------------------
   logic [PCT_W-1:0]  sat_clamped;
   logic [PCT_W-1:0]  bri_clamped;
   logic [31:0]       hue_prod;
   logic [HUE_W-1:0]  hue0_ff;
   logic [7:0]        quot0_in, quot0_ff;
   logic [PCT_W-1:0]  sat_inv0_in, sat_inv0_ff;
   logic [14:0]       bri255_0_in, bri255_0_ff;
   logic              err0_in, err0_ff;

   always_comb begin
      sat_clamped = (req_saturation > PCT_MAX) ? PCT_MAX : req_saturation;
      bri_clamped = (req_brightness > PCT_MAX) ? PCT_MAX : req_brightness;
      sat_inv0_in = PCT_MAX - sat_clamped;
      bri255_0_in = (15'(bri_clamped) << 8) - 15'(bri_clamped);
      hue_prod    = 32'(req_hue) * 32'(HUE_RECIP);
      quot0_in    = hue_prod[HUE_SHIFT+7:HUE_SHIFT];
      err0_in     = (req_hue > 16'(HUE_MOD - 1)) || (req_saturation > PCT_MAX) ||
                    (req_brightness > PCT_MAX);
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         hue0_ff     <= req_hue;
         quot0_ff    <= quot0_in;
         sat_inv0_ff <= sat_inv0_in;
         bri255_0_ff <= bri255_0_in;
         err0_ff     <= err0_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: hue residue (the multiply by 360 is a constant, so only
   // adders) and the peak level, floor(v * 255 / 100).
   // ------------------------------------------------------------------
   logic [16:0]       hue_sub;
   logic [16:0]       hue_res_full;
   logic [27:0]       peak_prod;
   logic [8:0]        h1_in, h1_ff;
   logic [CHAN_W-1:0] peak1_in, peak1_ff;
   logic [PCT_W-1:0]  sat_inv1_ff;
   logic              err1_ff;

   always_comb begin
      hue_sub      = 17'(quot0_ff) * 17'(HUE_MOD);
      hue_res_full = 17'(hue0_ff) - hue_sub;
      h1_in        = hue_res_full[8:0];
      peak_prod    = 28'(bri255_0_ff) * 28'(DIV100_RECIP);
      peak1_in     = peak_prod[DIV100_SHIFT+CHAN_W-1:DIV100_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         h1_ff       <= h1_in;
         peak1_ff    <= peak1_in;
         sat_inv1_ff <= sat_inv0_ff;
         err1_ff     <= err0_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: sector and remainder by comparison, and the floor
   // numerator peak * (100 - s).
   // ------------------------------------------------------------------
   sector_type        sector2_in, sector2_ff;
   logic [8:0]        sector_start;
   logic [8:0]        rem_full;
   logic [5:0]        rem2_in, rem2_ff;
   logic [14:0]       floor_num2_in, floor_num2_ff;
   logic [CHAN_W-1:0] peak2_ff;
   logic              err2_ff;

   always_comb begin
      if (h1_ff >= 9'(5 * SECTOR_DEG)) begin
         sector2_in   = SEC_R_PEAK_B_DOWN;
         sector_start = 9'(5 * SECTOR_DEG);
      end else if (h1_ff >= 9'(4 * SECTOR_DEG)) begin
         sector2_in   = SEC_B_PEAK_R_UP;
         sector_start = 9'(4 * SECTOR_DEG);
      end else if (h1_ff >= 9'(3 * SECTOR_DEG)) begin
         sector2_in   = SEC_B_PEAK_G_DOWN;
         sector_start = 9'(3 * SECTOR_DEG);
      end else if (h1_ff >= 9'(2 * SECTOR_DEG)) begin
         sector2_in   = SEC_G_PEAK_B_UP;
         sector_start = 9'(2 * SECTOR_DEG);
      end else if (h1_ff >= 9'(SECTOR_DEG)) begin
         sector2_in   = SEC_G_PEAK_R_DOWN;
         sector_start = 9'(SECTOR_DEG);
      end else begin
         sector2_in   = SEC_R_PEAK_G_UP;
         sector_start = 9'd0;
      end
      rem_full      = h1_ff - sector_start;
      rem2_in       = rem_full[5:0];
      floor_num2_in = 15'(peak1_ff) * 15'(sat_inv1_ff);
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         sector2_ff    <= sector2_in;
         rem2_ff       <= rem2_in;
         floor_num2_ff <= floor_num2_in;
         peak2_ff      <= peak1_ff;
         err2_ff       <= err1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: floor level by reciprocal divide by 100, and the span
   // between peak and floor.
   // ------------------------------------------------------------------
   logic [27:0]       base_prod;
   logic [CHAN_W-1:0] base3_in, base3_ff;
   logic [CHAN_W-1:0] diff3_in, diff3_ff;
   logic [CHAN_W-1:0] peak3_ff;
   sector_type        sector3_ff;
   logic [5:0]        rem3_ff;
   logic              err3_ff;

   always_comb begin
      base_prod = 28'(floor_num2_ff) * 28'(DIV100_RECIP);
      base3_in  = base_prod[DIV100_SHIFT+CHAN_W-1:DIV100_SHIFT];
      diff3_in  = peak2_ff - base3_in;
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         base3_ff   <= base3_in;
         diff3_ff   <= diff3_in;
         peak3_ff   <= peak2_ff;
         sector3_ff <= sector2_ff;
         rem3_ff    <= rem2_ff;
         err3_ff    <= err2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: ramp numerator, span times remainder.
   // ------------------------------------------------------------------
   logic [13:0]       ramp_num4_in, ramp_num4_ff;
   logic [CHAN_W-1:0] peak4_ff;
   logic [CHAN_W-1:0] base4_ff;
   sector_type        sector4_ff;
   logic              err4_ff;

   assign ramp_num4_in = 14'(diff3_ff) * 14'(rem3_ff);

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         ramp_num4_ff <= ramp_num4_in;
         peak4_ff     <= peak3_ff;
         base4_ff     <= base3_ff;
         sector4_ff   <= sector3_ff;
         err4_ff      <= err3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: ramp by reciprocal divide by 60, then the sector picks
   // which channel gets peak, floor, rising or falling level. This is
   // the output register.
   // ------------------------------------------------------------------
   logic [28:0]       ramp_prod;
   logic [CHAN_W-1:0] ramp;
   logic [CHAN_W-1:0] rising;
   logic [CHAN_W-1:0] falling;
   logic [CHAN_W-1:0] red5_in, red5_ff;
   logic [CHAN_W-1:0] green5_in, green5_ff;
   logic [CHAN_W-1:0] blue5_in, blue5_ff;
   logic              err5_ff;

   always_comb begin
      ramp_prod = 29'(ramp_num4_ff) * 29'(DIV60_RECIP);
      ramp      = ramp_prod[DIV60_SHIFT+CHAN_W-1:DIV60_SHIFT];
      rising    = base4_ff + ramp;
      falling   = peak4_ff - ramp;
      case (sector4_ff)
         SEC_R_PEAK_G_UP: begin
            red5_in = peak4_ff; green5_in = rising;   blue5_in = base4_ff;
         end
         SEC_G_PEAK_R_DOWN: begin
            red5_in = falling;  green5_in = peak4_ff; blue5_in = base4_ff;
         end
         SEC_G_PEAK_B_UP: begin
            red5_in = base4_ff; green5_in = peak4_ff; blue5_in = rising;
         end
         SEC_B_PEAK_G_DOWN: begin
            red5_in = base4_ff; green5_in = falling;  blue5_in = peak4_ff;
         end
         SEC_B_PEAK_R_UP: begin
            red5_in = rising;   green5_in = base4_ff; blue5_in = peak4_ff;
         end
         default: begin
            red5_in = peak4_ff; green5_in = base4_ff; blue5_in = falling;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[5]) begin
         red5_ff   <= red5_in;
         green5_ff <= green5_in;
         blue5_ff  <= blue5_in;
         err5_ff   <= err4_ff;
      end
   end

   assign rsp_red         = red5_ff;
   assign rsp_green       = green5_ff;
   assign rsp_blue        = blue5_ff;
   assign rsp_range_error = err5_ff;

   // ------------------------------------------------------------------
   // Checks on the arithmetic and on the stage handshake.
   // ------------------------------------------------------------------
   `HSV_ASSERT(a_hue_residue, clock, reset, (valid_ff[1] |-> h1_ff < 9'(HUE_MOD)), "hue residue out of range")
   `HSV_ASSERT(a_sector_rem, clock, reset, (valid_ff[2] |-> rem2_ff < 6'(SECTOR_DEG)), "sector remainder out of range")
   `HSV_ASSERT(a_floor_le_peak, clock, reset, (valid_ff[3] |-> base3_ff <= peak3_ff), "floor level above peak")
   `HSV_ASSERT(a_ramp_le_span, clock, reset, (valid_ff[4] |-> ramp <= peak4_ff - base4_ff), "ramp exceeds span")
   `HSV_ASSERT(a_stage_held, clock, reset, (valid_ff[2] && !ready[3] |=> valid_ff[2]), "held beat dropped")

endmodule
